### rtl/vdle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdle_pkg
// Shared constants, opcode codes and the result record of the vector
// display list engine.
// ----------------------------------------------------------------------------
package vdle_pkg;

  // Return stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH);

  // Reset and frame start values
  localparam logic [15:0] START_RESET = 16'h4000;
  localparam logic [15:0] JUMP_BASE   = 16'h2000;
  localparam logic [19:0] BEAM_HOME   = 20'd2048;
  localparam logic [3:0]  SCALE_FRAME = 4'd1;
  localparam logic [3:0]  SCALE_UNITY = 4'd8;
  localparam logic [3:0]  LONG_TOP    = 4'd9;

  // Item operations
  localparam logic OPR_FRAME = 1'b0;
  localparam logic OPR_EXEC  = 1'b1;

  // Opcodes in the upper nibble of byte 1 (1..9 are long vectors)
  localparam logic [3:0] OP_HALT_ZERO = 4'h0;
  localparam logic [3:0] OP_POSITION  = 4'hA;
  localparam logic [3:0] OP_HALT      = 4'hB;
  localparam logic [3:0] OP_CALL      = 4'hC;
  localparam logic [3:0] OP_RETURN    = 4'hD;
  localparam logic [3:0] OP_JUMP      = 4'hE;
  localparam logic [3:0] OP_SHORT     = 4'hF;

  // One result transaction
  typedef struct packed {
    logic [15:0]        next_address;
    logic               draw_visible;
    logic signed [19:0] start_x;
    logic signed [19:0] start_y;
    logic signed [19:0] end_x;
    logic signed [19:0] end_y;
    logic               halted;
  } result_t;

endpackage

### rtl/vector_display_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_display_list_engine_unit
// Executes a vector display list one instruction per transaction: beam
// moves, scaling, jumps, calls and returns through a return stack memory.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, operation, bytes   | consumer
//  out     | out_valid_o/out_ready_i, result fields    | producer
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i       | consumer
//
//  One instruction per cycle while in_ready_o is high; each result is
//  registered in the output or skid register. The return stack memory
//  keeps its top entry in a registered read tracking the SP every cycle.
//  Reset clears control state only; the stack needs no clearing pass.
//  A stalled output fills the skid entry, then in_ready_o drops.
//  cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module vector_display_list_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [7:0]         instr_byte0_i,
  input  logic [7:0]         instr_byte1_i,
  input  logic [7:0]         instr_byte2_i,
  input  logic [7:0]         instr_byte3_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_address_o,
  output logic               draw_visible_o,
  output logic signed [19:0] start_x_o,
  output logic signed [19:0] start_y_o,
  output logic signed [19:0] end_x_o,
  output logic signed [19:0] end_y_o,
  output logic               halted_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import vdle_pkg::*;

  logic [15:0]     start_q;
  logic [15:0]     pc_q, pc_d;
  logic [19:0]     bx_q, bx_d, by_q, by_d;
  logic [3:0]      gs_q, gs_d;
  logic [SP_W-1:0] sp_q, sp_d, rd_addr;
  logic            halt_q, halt_d;
  logic            in_fire, lit, push;
  logic [15:0]     top;
  logic [3:0]      opc;
  logic [19:0]     sx, sy;
  logic [9:0]      mag_x, mag_y;
  logic [1:0]      sv_sh;
  logic [3:0]      lv_sh;
  logic [15:0]     jtgt;
  result_t         res;

  function automatic logic [SP_W-1:0] sp_inc(input logic [SP_W-1:0] p);
    return (p == SP_W'(STACK_DEPTH - 1)) ? '0 : p + SP_W'(1);
  endfunction

  function automatic logic [SP_W-1:0] sp_dec(input logic [SP_W-1:0] p);
    return (p == '0) ? SP_W'(STACK_DEPTH - 1) : p - SP_W'(1);
  endfunction

  // Global scale: 8 keeps, above 8 shifts right by 16 - g, below shifts left
  function automatic logic [19:0] gscale(input logic [9:0] m, input logic [3:0] g);
    logic [19:0] m20;
    m20 = 20'(m);
    if (g == SCALE_UNITY) begin
      return m20;
    end else if (g > SCALE_UNITY) begin
      return m20 >> (4'(5'd16 - 5'(g)));
    end
    return m20 << g;
  endfunction

  function automatic logic [19:0] move(input logic [19:0] pos, input logic [19:0] mag,
                                       input logic neg);
    return neg ? (pos - mag) : (pos + mag);
  endfunction

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign opc         = instr_byte1_i[7:4];
  assign jtgt        = 16'((16'({instr_byte1_i[3:0], instr_byte0_i}) + JUMP_BASE) << 1);
  assign sv_sh       = {instr_byte0_i[3], instr_byte1_i[3]};
  assign lv_sh       = LONG_TOP - opc;

  // Decode and execute one instruction
  always_comb begin
    pc_d   = pc_q;
    bx_d   = bx_q;
    by_d   = by_q;
    gs_d   = gs_q;
    sp_d   = sp_q;
    halt_d = halt_q;
    lit    = 1'b0;
    push   = 1'b0;
    sx     = bx_q;
    sy     = by_q;
    mag_x  = '0;
    mag_y  = '0;
    if (in_fire) begin
      if (operation_i == OPR_FRAME) begin
        pc_d   = start_q;
        bx_d   = BEAM_HOME;
        by_d   = BEAM_HOME;
        gs_d   = SCALE_FRAME;
        sp_d   = '0;
        halt_d = 1'b0;
        sx     = BEAM_HOME;
        sy     = BEAM_HOME;
      end else if (!halt_q) begin
        case (opc)
          OP_HALT_ZERO, OP_HALT: begin
            halt_d = 1'b1;
          end
          OP_POSITION: begin
            gs_d = instr_byte3_i[7:4];
            by_d = 20'({instr_byte1_i[3:0], instr_byte0_i});
            bx_d = 20'({instr_byte3_i[3:0], instr_byte2_i});
            pc_d = pc_q + 16'd4;
          end
          OP_CALL: begin
            push = 1'b1;
            sp_d = sp_inc(sp_q);
            pc_d = jtgt;
          end
          OP_RETURN: begin
            sp_d = sp_dec(sp_q);
            pc_d = top;
          end
          OP_JUMP: begin
            pc_d = jtgt;
          end
          OP_SHORT: begin
            lit   = instr_byte0_i[7:4] != 4'd0;
            mag_x = 10'({instr_byte0_i[1:0], 1'b0}) << sv_sh;
            mag_y = 10'({instr_byte1_i[1:0], 1'b0}) << sv_sh;
            bx_d  = move(bx_q, gscale(mag_x, gs_q), instr_byte0_i[2]);
            by_d  = move(by_q, gscale(mag_y, gs_q), instr_byte1_i[2]);
            pc_d  = pc_q + 16'd2;
          end
          default: begin
            // long vector, opcodes 1 to 9
            lit   = instr_byte3_i[7:4] != 4'd0;
            mag_y = {instr_byte1_i[1:0], instr_byte0_i} >> lv_sh;
            mag_x = {instr_byte3_i[1:0], instr_byte2_i} >> lv_sh;
            bx_d  = move(bx_q, gscale(mag_x, gs_q), instr_byte3_i[2]);
            by_d  = move(by_q, gscale(mag_y, gs_q), instr_byte1_i[2]);
            pc_d  = pc_q + 16'd4;
          end
        endcase
      end
    end
  end

  // Track the top entry at the next stack pointer
  assign rd_addr = sp_dec(sp_d);

  vdle_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (sp_q),
    .wdata_i (pc_q + 16'd2),
    .raddr_i (rd_addr),
    .top_o   (top)
  );

  // Update engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      pc_q    <= START_RESET;
      bx_q    <= BEAM_HOME;
      by_q    <= BEAM_HOME;
      gs_q    <= SCALE_FRAME;
      sp_q    <= '0;
      halt_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        start_q <= cfg_data_i;
      end
      pc_q   <= pc_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      gs_q   <= gs_d;
      sp_q   <= sp_d;
      halt_q <= halt_d;
    end
  end

  // Assemble the result transaction
  always_comb begin
    res.next_address = pc_d;
    res.draw_visible = lit;
    res.start_x      = $signed(sx);
    res.start_y      = $signed(sy);
    res.end_x        = $signed(bx_d);
    res.end_y        = $signed(by_d);
    res.halted       = halt_d;
  end

  result_t out_res;

  vdle_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign next_address_o = out_res.next_address;
  assign draw_visible_o = out_res.draw_visible;
  assign start_x_o      = out_res.start_x;
  assign start_y_o      = out_res.start_y;
  assign end_x_o        = out_res.end_x;
  assign end_y_o        = out_res.end_y;
  assign halted_o       = out_res.halted;

  // A halted engine ignores instructions
  a_halt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (operation_i == OPR_EXEC) && halt_q |=>
      (pc_q == $past(pc_q)) && (bx_q == $past(bx_q)) && (by_q == $past(by_q)))
    else $error("halted engine changed state");

  // Frame start homes the beam and empties the stack
  a_frame_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (operation_i == OPR_FRAME) |=>
      (bx_q == BEAM_HOME) && (by_q == BEAM_HOME) && (sp_q == '0) && !halt_q)
    else $error("frame start did not home the engine");

  // A pushed return address is visible as the top entry next cycle
  a_push_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (top == $past(pc_q) + 16'd2))
    else $error("return stack top not forwarded after call");

  // Input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

### rtl/vdle_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdle_stack
// Return stack memory with a registered top-of-stack read. A write to the
// address being read in the same cycle is forwarded to the read register.
// ----------------------------------------------------------------------------
module vdle_stack (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [vdle_pkg::SP_W-1:0] waddr_i,
  input  logic [15:0]               wdata_i,
  input  logic [vdle_pkg::SP_W-1:0] raddr_i,
  output logic [15:0]               top_o
);
  import vdle_pkg::*;

  logic [15:0] mem [STACK_DEPTH];
  logic [15:0] top_q;

  // Write the pushed address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read the top entry, write data first on an address match
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      top_q <= wdata_i;
    end else begin
      top_q <= mem[raddr_i];
    end
  end

  assign top_o = top_q;

endmodule

### rtl/vdle_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdle_outbuf
// Two-entry output buffer: an output register plus a skid register, so the
// input side can take one more result while a result waits for the consumer.
// ----------------------------------------------------------------------------
module vdle_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vdle_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vdle_pkg::result_t out_data_o
);
  import vdle_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, skid_data_q;
  logic    in_fire, out_fire, load_out, load_skid, move_skid;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Steer the incoming transaction and drain the skid entry
  always_comb begin
    load_out     = 1'b0;
    load_skid    = 1'b0;
    move_skid    = 1'b0;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_fire) begin
      if (skid_valid_q) begin
        move_skid    = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payloads until replaced
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= in_data_i;
    end else if (move_skid) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
